// ===== rtl/core/pst_pkg.sv =====
// Package for the pot signal search tracker.
// Holds register indexes, reset values, stage codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package pst_pkg;

    // Default full-scale pot level
    localparam int LEVEL_MAX_DEF = 255;

    // Field widths on the ports
    localparam int SAMPLE_W = 16;
    localparam int GAP_W    = 7;
    localparam int COUNT_W  = 10;
    localparam int CENTER_W = 8;
    localparam int LVL_W    = 8;
    localparam int STAGE_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 16;
    localparam int OUT_W    = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd3;

    // Configuration reset values
    localparam logic [SAMPLE_W-1:0] TARGET_RST = 16'd32768;
    localparam logic [GAP_W-1:0]    GAP_RST    = 7'd8;
    localparam logic [COUNT_W-1:0]  LIMIT_RST  = 10'd400;
    localparam logic [CENTER_W-1:0] CENTER_RST = 8'd128;

    // Request kinds
    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Procedure stage codes
    localparam logic [STAGE_W-1:0] STAGE_SEARCH  = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_CAPTURE = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_TRACK   = 2'd2;
    localparam logic [STAGE_W-1:0] STAGE_DONE    = 2'd3;

    // Configuration register set
    typedef struct packed {
        logic [SAMPLE_W-1:0] target;
        logic [GAP_W-1:0]    gap;
        logic [COUNT_W-1:0]  limit;
        logic [CENTER_W-1:0] center;
    } cfg_t;

    // Control part of the procedure state
    typedef struct packed {
        logic [STAGE_W-1:0] stage;
        logic               side;
        logic               found;
        logic [COUNT_W-1:0] count;
    } ctrl_t;

endpackage

// ===== rtl/core/pst_step.sv =====
// Next-state logic of the pot signal search tracker for one word.
// Depends on pst_pkg.
`timescale 1ns / 1ps

module pst_step #(
    parameter int LEVEL_MAX = pst_pkg::LEVEL_MAX_DEF,
    parameter int LW        = $clog2(LEVEL_MAX + 1)
) (
    input  pst_pkg::cfg_t                 cfg,
    input  logic                          req_type,
    input  logic [pst_pkg::SAMPLE_W-1:0]  sample,
    input  pst_pkg::ctrl_t                ctrl,
    input  logic [LW-1:0]                 wiper,
    input  logic [LW-1:0]                 win_high,
    input  logic [LW-1:0]                 win_low,
    input  logic [LW-1:0]                 top,
    input  logic [LW-1:0]                 bottom,
    output pst_pkg::ctrl_t                ctrl_next,
    output logic [LW-1:0]                 wiper_next,
    output logic [LW-1:0]                 win_high_next,
    output logic [LW-1:0]                 win_low_next,
    output logic [LW-1:0]                 top_next,
    output logic [LW-1:0]                 bottom_next
);

    import pst_pkg::*;

    // Signed work width: holds level and gap differences with room for a step
    localparam int DW = ((LW > 8) ? LW : 8) + 2;

    typedef logic signed [DW-1:0] sv_t;

    localparam sv_t MAX_S = sv_t'(LEVEL_MAX);

    function automatic sv_t to_s(input logic [LW-1:0] x);
        return $signed(DW'(x));
    endfunction

    function automatic logic [LW-1:0] sat(input sv_t v);
        logic [LW-1:0] r;
        if (v < sv_t'(0))
            r = '0;
        else if (v > MAX_S)
            r = LW'(LEVEL_MAX);
        else
            r = LW'(v);
        return r;
    endfunction

    logic          below;
    logic [LW-1:0] center;
    sv_t           center_s;
    sv_t           gap_s;
    sv_t           gap2_s;
    sv_t           d;
    sv_t           ad;
    sv_t           mag;
    logic [LW:0]   sum;

    // Side of the target and clamped center level
    always_comb
    begin
        below    = sample < cfg.target;
        center_s = $signed(DW'(cfg.center));
        center   = (center_s > MAX_S) ? LW'(LEVEL_MAX) : LW'(cfg.center);
        gap_s    = $signed(DW'(cfg.gap));
        gap2_s   = $signed(DW'({cfg.gap, 1'b0}));
    end

    // Drag step toward center: clamp(|d|/4, 1, 3)
    always_comb
    begin
        d   = to_s(wiper) - to_s(center);
        ad  = (d < sv_t'(0)) ? -d : d;
        if (ad < sv_t'(8))
            mag = sv_t'(1);
        else if (ad < sv_t'(12))
            mag = sv_t'(2);
        else
            mag = sv_t'(3);
    end

    // Update the procedure state for one word
    always_comb
    begin
        ctrl_next     = ctrl;
        wiper_next    = wiper;
        win_high_next = win_high;
        win_low_next  = win_low;
        top_next      = top;
        bottom_next   = bottom;
        sum           = '0;

        if (req_type == REQ_START)
        begin
            top_next        = LW'(LEVEL_MAX);
            bottom_next     = '0;
            wiper_next      = center;
            win_high_next   = LW'(LEVEL_MAX);
            win_low_next    = '0;
            ctrl_next.side  = 1'b0;
            ctrl_next.found = 1'b0;
            ctrl_next.count = '0;
            ctrl_next.stage = (MAX_S > gap2_s) ? STAGE_SEARCH : STAGE_CAPTURE;
        end
        else
        begin
            case (ctrl.stage)
                STAGE_SEARCH:
                begin
                    // Halve the window around the wiper
                    if (below)
                    begin
                        win_low_next = wiper;
                        sum          = (LW + 1)'(wiper) + (LW + 1)'(win_high);
                    end
                    else
                    begin
                        win_high_next = wiper;
                        sum           = (LW + 1)'(wiper) + (LW + 1)'(win_low);
                    end
                    wiper_next = LW'(sum >> 1);
                    if (to_s(win_high_next) - to_s(win_low_next) <= gap2_s)
                        ctrl_next.stage = STAGE_CAPTURE;
                end
                STAGE_CAPTURE:
                begin
                    ctrl_next.side = below;
                    if ((to_s(top) - to_s(bottom) > gap_s) && (ctrl.count < cfg.limit))
                        ctrl_next.stage = STAGE_TRACK;
                    else
                        ctrl_next.stage = STAGE_DONE;
                end
                STAGE_TRACK:
                begin
                    if (!ctrl.found)
                    begin
                        // Step the wiper until the side flips
                        if (below == ctrl.side)
                            wiper_next = sat(below ? to_s(wiper) + sv_t'(1)
                                                   : to_s(wiper) - sv_t'(1));
                        else
                            ctrl_next.found = 1'b1;
                    end
                    else
                    begin
                        // Narrow one edge and drag the wiper toward center
                        if (below)
                            top_next = sat(to_s(top) - sv_t'(1));
                        else
                            bottom_next = sat(to_s(bottom) + sv_t'(1));
                        if (wiper != center)
                            wiper_next = sat((d > sv_t'(0)) ? to_s(wiper) - mag
                                                            : to_s(wiper) + mag);
                    end
                    ctrl_next.count = ctrl.count + 1'b1;
                    if ((to_s(top_next) - to_s(bottom_next) > gap_s)
                        && (ctrl_next.count < cfg.limit))
                        ctrl_next.stage = STAGE_TRACK;
                    else
                        ctrl_next.stage = STAGE_DONE;
                end
                default:
                begin
                    ctrl_next = ctrl;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/pot_signal_search_tracker.sv =====
// Pot signal search tracker: calibrates top, bottom and middle pot levels from
// a stream of sensor samples. A start word (tuser 0) resets the levels; sample
// words (tuser 1) then run a binary search on the middle wiper, capture the
// initial side of the target, and track until the side flips, narrowing top or
// bottom afterwards until the gap or the iteration limit ends it. Every input
// word gives one output word with the levels and stage after that word. The
// block takes one word per clock cycle while the output is not stalled;
// each word passes an input register and a result register, with the whole
// state update done combinationally between them. Write configuration
// only while idle. Depends on pst_pkg and pst_step.
`timescale 1ns / 1ps

module pot_signal_search_tracker #(
    parameter int LEVEL_MAX = pst_pkg::LEVEL_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pst_pkg::SAMPLE_W-1:0]    s_tdata,   // [15:0] sample
    input  logic                            s_tuser,   // [0] req_type
    // Output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] top_level, [15:8] bottom_level, [23:16] middle_level,
    // [25:24] stage, [26] signal_found, [31:27] zero
    output logic [pst_pkg::OUT_W-1:0]       m_tdata,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [pst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pst_pkg::CFG_W-1:0]       cfg_data
);

    import pst_pkg::*;

    localparam int LW = $clog2(LEVEL_MAX + 1);

    cfg_t                cfg_reg;
    logic                in_valid_reg;
    logic                in_req_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    ctrl_t               ctrl_reg;
    ctrl_t               ctrl_next;
    logic [LW-1:0]       wiper_reg;
    logic [LW-1:0]       wiper_next;
    logic [LW-1:0]       win_high_reg;
    logic [LW-1:0]       win_high_next;
    logic [LW-1:0]       win_low_reg;
    logic [LW-1:0]       win_low_next;
    logic [LW-1:0]       top_reg;
    logic [LW-1:0]       top_next;
    logic [LW-1:0]       bottom_reg;
    logic [LW-1:0]       bottom_next;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;
    logic [OUT_W-1:0]    out_data_next;
    logic                advance;

    // Move a word to the result register when it is empty or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target <= TARGET_RST;
            cfg_reg.gap    <= GAP_RST;
            cfg_reg.limit  <= LIMIT_RST;
            cfg_reg.center <= CENTER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET: cfg_reg.target <= cfg_data;
                REG_GAP:    cfg_reg.gap    <= cfg_data[GAP_W-1:0];
                REG_LIMIT:  cfg_reg.limit  <= cfg_data[COUNT_W-1:0];
                REG_CENTER: cfg_reg.center <= cfg_data[CENTER_W-1:0];
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg    <= s_tuser;
            in_sample_reg <= s_tdata;
        end
    end

    pst_step #(
        .LEVEL_MAX (LEVEL_MAX),
        .LW        (LW)
    ) u_step (
        .cfg           (cfg_reg),
        .req_type      (in_req_reg),
        .sample        (in_sample_reg),
        .ctrl          (ctrl_reg),
        .wiper         (wiper_reg),
        .win_high      (win_high_reg),
        .win_low       (win_low_reg),
        .top           (top_reg),
        .bottom        (bottom_reg),
        .ctrl_next     (ctrl_next),
        .wiper_next    (wiper_next),
        .win_high_next (win_high_next),
        .win_low_next  (win_low_next),
        .top_next      (top_next),
        .bottom_next   (bottom_next)
    );

    // Pack the result word
    assign out_data_next = {(OUT_W - 3 * LVL_W - STAGE_W - 1)'(0),
                            ctrl_next.found,
                            ctrl_next.stage,
                            LVL_W'(wiper_next),
                            LVL_W'(bottom_next),
                            LVL_W'(top_next)};

    // Advance procedure state on each word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.stage <= STAGE_DONE;
            ctrl_reg.side  <= 1'b0;
            ctrl_reg.found <= 1'b0;
            ctrl_reg.count <= '0;
            wiper_reg      <= '0;
            win_high_reg   <= LW'(LEVEL_MAX);
            win_low_reg    <= '0;
            top_reg        <= LW'(LEVEL_MAX);
            bottom_reg     <= '0;
        end
        else if (advance)
        begin
            ctrl_reg     <= ctrl_next;
            wiper_reg    <= wiper_next;
            win_high_reg <= win_high_next;
            win_low_reg  <= win_low_next;
            top_reg      <= top_next;
            bottom_reg   <= bottom_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/core/pst_checker.sv =====
// Port-level checks for the pot signal search tracker, bound to the top level.
// Depends on pst_pkg and pot_signal_search_tracker.
`timescale 1ns / 1ps

module pst_checker #(
    parameter int LEVEL_MAX = pst_pkg::LEVEL_MAX_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pst_pkg::OUT_W-1:0]     m_tdata
);

    import pst_pkg::*;

    logic [LVL_W-1:0]   top_f;
    logic [LVL_W-1:0]   bottom_f;
    logic [STAGE_W-1:0] stage_f;
    logic               found_f;

    assign top_f    = m_tdata[LVL_W-1:0];
    assign bottom_f = m_tdata[2*LVL_W-1:LVL_W];
    assign stage_f  = m_tdata[3*LVL_W+STAGE_W-1:3*LVL_W];
    assign found_f  = m_tdata[3*LVL_W+STAGE_W];

    // Stalled word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Found flag is only set after tracking started
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (stage_f == STAGE_SEARCH || stage_f == STAGE_CAPTURE) |-> !found_f)
        else $error("signal found reported before tracking");

    // Top and bottom stay at full range until tracking narrows them
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (stage_f == STAGE_SEARCH || stage_f == STAGE_CAPTURE)
        |-> top_f == LVL_W'(LEVEL_MAX) && bottom_f == '0)
        else $error("top or bottom moved before tracking");

    // Padding bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1:3*LVL_W+STAGE_W+1] == '0)
        else $error("nonzero padding in output word");

endmodule

bind pot_signal_search_tracker pst_checker #(
    .LEVEL_MAX (LEVEL_MAX)
) u_pst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
